// File: rtl/assert_macros.svh
// Assertion macros used by the top-level RTL file.
// Depends on nothing; the assertion bodies drop out under SYNTHESIS.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_SYNC(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
        else $error("assertion failed");
`define ASSERT_SYNC_ALWAYS(label, clk, prop) \
    label: assert property (@(posedge clk) (prop)) else $error("assertion failed");
`else
`define ASSERT_SYNC(label, clk, rst_n, prop)
`define ASSERT_SYNC_ALWAYS(label, clk, prop)
`endif
`endif

// File: rtl/hpim_pkg.sv
// Shared types and constants for the Halton pixel index mapper.
// Used by hpim_digit_cell, hpim_addr_stage and the top level.
package hpim_pkg;

    localparam int IDX_W    = 25;
    localparam int DIM_W    = 13;
    localparam int DCNT_W   = 5;
    localparam int PX_W     = 12;
    localparam int PY_W     = 13;
    localparam int ADDR_W   = 24;
    localparam int S_TDATA_W = 32;
    localparam int M_TDATA_W = 80;
    localparam int CFG_IDX_W = 2;

    // floor(v / 3) == (v * RECIP3) >> RECIP3_SH for any 25-bit v
    localparam logic [25:0] RECIP3    = 26'd22369622;
    localparam int          RECIP3_SH = 26;

    localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_BASE2  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_BASE3  = 2'd3;

    typedef struct packed {
        logic [DIM_W-1:0]  width;
        logic [DIM_W-1:0]  height;
        logic [DCNT_W-1:0] d2;
        logic [DCNT_W-1:0] d3;
    } cfg_t;

    function automatic int pow3(input int n);
        int p;
        p = 1;
        for (int i = 0; i < n; i++) begin
            p = p * 3;
        end
        return p;
    endfunction

endpackage

// File: rtl/hpim_digit_cell.sv
// Digit cell K: takes index bit K and ternary digit K per beat, where enabled.
// Depends on hpim_pkg.
module hpim_digit_cell #(
    parameter int K       = 0,
    parameter int X_W     = 12,
    parameter int Y_W     = 13,
    parameter bit BIN_EN  = 1'b1,
    parameter bit TERN_EN = 1'b1
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  hpim_pkg::cfg_t                cfg,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [hpim_pkg::IDX_W-1:0]    in_idx,
    input  logic [hpim_pkg::IDX_W-1:0]    in_rem,
    input  logic [X_W-1:0]                in_x,
    input  logic [Y_W-1:0]                in_y,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [hpim_pkg::IDX_W-1:0]    out_idx,
    output logic [hpim_pkg::IDX_W-1:0]    out_rem,
    output logic [X_W-1:0]                out_x,
    output logic [Y_W-1:0]                out_y
);

    localparam int DCNT_W = hpim_pkg::DCNT_W;

    logic                       valid_reg;
    logic [hpim_pkg::IDX_W-1:0] idx_reg;
    logic [hpim_pkg::IDX_W-1:0] rem_reg, rem_next;
    logic [X_W-1:0]             x_reg, x_next;
    logic [Y_W-1:0]             y_reg, y_next;
    logic                       load;

    assign in_ready = !valid_reg || out_ready;
    assign load     = in_valid && in_ready;

    generate
        if (BIN_EN) begin : g_bin
            always_comb begin
                if (DCNT_W'(K) < cfg.d2) begin
                    x_next = X_W'({in_x, in_idx[K]});
                end else begin
                    x_next = in_x;
                end
            end
        end else begin : g_no_bin
            assign x_next = in_x;
        end

        if (TERN_EN) begin : g_tern
            logic [hpim_pkg::IDX_W+25:0] prod;
            logic [hpim_pkg::IDX_W-1:0]  quot;
            logic [1:0]                  digit;
            logic [hpim_pkg::IDX_W+1:0]  q3;
            logic [Y_W+1:0]              y3;

            assign prod  = (hpim_pkg::IDX_W+26)'(in_rem) * (hpim_pkg::IDX_W+26)'(hpim_pkg::RECIP3);
            assign quot  = hpim_pkg::IDX_W'(prod >> hpim_pkg::RECIP3_SH);
            assign q3    = (hpim_pkg::IDX_W+2)'(quot) + (hpim_pkg::IDX_W+2)'({quot, 1'b0});
            assign digit = 2'((hpim_pkg::IDX_W+2)'(in_rem) - q3);
            assign y3    = (Y_W+2)'(in_y) + (Y_W+2)'({in_y, 1'b0}) + (Y_W+2)'(digit);

            always_comb begin
                if (DCNT_W'(K) < cfg.d3) begin
                    y_next   = Y_W'(y3);
                    rem_next = quot;
                end else begin
                    y_next   = in_y;
                    rem_next = in_rem;
                end
            end
        end else begin : g_no_tern
            assign y_next   = in_y;
            assign rem_next = in_rem;
        end
    endgenerate

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            idx_reg <= in_idx;
            rem_reg <= rem_next;
            x_reg   <= x_next;
            y_reg   <= y_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_idx   = idx_reg;
    assign out_rem   = rem_reg;
    assign out_x     = x_reg;
    assign out_y     = y_reg;

endmodule

// File: rtl/hpim_addr_stage.sv
// Address and range stage with the output register of the mapper.
// Depends on hpim_pkg.
module hpim_addr_stage #(
    parameter int X_W = 12,
    parameter int Y_W = 13
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  hpim_pkg::cfg_t                cfg,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [hpim_pkg::IDX_W-1:0]    in_idx,
    input  logic [X_W-1:0]                in_x,
    input  logic [Y_W-1:0]                in_y,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [hpim_pkg::PX_W-1:0]     pixel_x,
    output logic [hpim_pkg::PY_W-1:0]     pixel_y,
    output logic [hpim_pkg::ADDR_W-1:0]   table_address,
    output logic                          write_enable,
    output logic [hpim_pkg::IDX_W-1:0]    index_out
);

    localparam int DIM_W  = hpim_pkg::DIM_W;
    localparam int XC_W   = (X_W > DIM_W) ? X_W : DIM_W;
    localparam int YC_W   = (Y_W > DIM_W) ? Y_W : DIM_W;
    localparam int XE_W   = (X_W > hpim_pkg::PX_W) ? X_W : hpim_pkg::PX_W;
    localparam int YE_W   = (Y_W > hpim_pkg::PY_W) ? Y_W : hpim_pkg::PY_W;
    localparam int PROD_W = Y_W + DIM_W;
    localparam int SUM_W  = (PROD_W + 1 > hpim_pkg::ADDR_W) ? PROD_W + 1 : hpim_pkg::ADDR_W;

    logic                          valid_reg;
    logic [hpim_pkg::PX_W-1:0]     px_reg;
    logic [hpim_pkg::PY_W-1:0]     py_reg;
    logic [hpim_pkg::ADDR_W-1:0]   addr_reg, addr_next;
    logic                          we_reg, we_next;
    logic [hpim_pkg::IDX_W-1:0]    idx_reg;
    logic [PROD_W-1:0]             prod;
    logic [SUM_W-1:0]              sum;
    logic [XE_W-1:0]               x_ext;
    logic [YE_W-1:0]               y_ext;

    assign in_ready = !valid_reg || out_ready;

    assign prod    = PROD_W'(in_y) * PROD_W'(cfg.width);
    assign sum     = SUM_W'(prod) + SUM_W'(in_x);
    assign we_next = (XC_W'(in_x) < XC_W'(cfg.width)) && (YC_W'(in_y) < YC_W'(cfg.height));
    assign addr_next = we_next ? sum[hpim_pkg::ADDR_W-1:0] : '0;
    assign x_ext   = XE_W'(in_x);
    assign y_ext   = YE_W'(in_y);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_valid && in_ready) begin
            px_reg   <= x_ext[hpim_pkg::PX_W-1:0];
            py_reg   <= y_ext[hpim_pkg::PY_W-1:0];
            addr_reg <= addr_next;
            we_reg   <= we_next;
            idx_reg  <= in_idx;
        end
    end

    assign out_valid     = valid_reg;
    assign pixel_x       = px_reg;
    assign pixel_y       = py_reg;
    assign table_address = addr_reg;
    assign write_enable  = we_reg;
    assign index_out     = idx_reg;

endmodule

// File: rtl/halton_pixel_index_mapper.sv
// Top level of the Halton pixel index mapper: config registers, cell chain, output.
// Depends on hpim_pkg, hpim_digit_cell, hpim_addr_stage and assert_macros.svh.
//
//   channel | dir | handshake          | payload
//   s_      | in  | s_tvalid/s_tready  | s_tdata: sample_index
//   m_      | out | m_tvalid/m_tready  | m_tdata: x, y, address, index; m_tuser: write flag
//   cfg_    | in  | cfg_valid/cfg_ready| cfg_index, cfg_data
//
// One beat per cycle sustained while m_tready stays high; a beat passes through the digit
// cell registers in order, then the address multiply into the output register.
// Reset clears all stage valid flags and loads the register defaults.
// A stall on m_tready backs up stage by stage; empty stages keep taking beats.
`include "assert_macros.svh"

module halton_pixel_index_mapper #(
    parameter int MAX_BASE2_DIGITS = 12,
    parameter int MAX_BASE3_DIGITS = 8
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // [24:0] sample_index
    input  logic [hpim_pkg::S_TDATA_W-1:0]     s_tdata,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // [11:0] pixel_x, [24:12] pixel_y, [48:25] table_address, [73:49] index_out
    output logic [hpim_pkg::M_TDATA_W-1:0]     m_tdata,
    // [0] write_enable
    output logic [0:0]                         m_tuser,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [hpim_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [hpim_pkg::DIM_W-1:0]         cfg_data
);

    localparam int NC     = (MAX_BASE2_DIGITS > MAX_BASE3_DIGITS) ?
                            MAX_BASE2_DIGITS : MAX_BASE3_DIGITS;
    localparam int X_W    = MAX_BASE2_DIGITS;
    localparam int Y_W    = $clog2(hpim_pkg::pow3(MAX_BASE3_DIGITS));
    localparam int IDX_W  = hpim_pkg::IDX_W;
    localparam int DIM_W  = hpim_pkg::DIM_W;
    localparam int DCNT_W = hpim_pkg::DCNT_W;

    logic [DIM_W-1:0] width_reg;
    logic [DIM_W-1:0] height_reg;
    logic [3:0]       base2_reg;
    logic [3:0]       base3_reg;
    hpim_pkg::cfg_t   cfg;

    logic             v_w   [NC+1];
    logic             r_w   [NC+1];
    logic [IDX_W-1:0] idx_w [NC+1];
    logic [IDX_W-1:0] rem_w [NC+1];
    logic [X_W-1:0]   x_w   [NC+1];
    logic [Y_W-1:0]   y_w   [NC+1];

    logic [hpim_pkg::PX_W-1:0]   pixel_x;
    logic [hpim_pkg::PY_W-1:0]   pixel_y;
    logic [hpim_pkg::ADDR_W-1:0] table_address;
    logic                        write_enable;
    logic [IDX_W-1:0]            index_out;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg  <= DIM_W'(4096);
            height_reg <= DIM_W'(4096);
            base2_reg  <= 4'd12;
            base3_reg  <= 4'd8;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                hpim_pkg::REG_WIDTH:  width_reg  <= cfg_data;
                hpim_pkg::REG_HEIGHT: height_reg <= cfg_data;
                hpim_pkg::REG_BASE2:  base2_reg  <= cfg_data[3:0];
                hpim_pkg::REG_BASE3:  base3_reg  <= cfg_data[3:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        cfg.width  = width_reg;
        cfg.height = height_reg;
        cfg.d2 = (DCNT_W'(base2_reg) > DCNT_W'(MAX_BASE2_DIGITS)) ?
                 DCNT_W'(MAX_BASE2_DIGITS) : DCNT_W'(base2_reg);
        cfg.d3 = (DCNT_W'(base3_reg) > DCNT_W'(MAX_BASE3_DIGITS)) ?
                 DCNT_W'(MAX_BASE3_DIGITS) : DCNT_W'(base3_reg);
    end

    assign v_w[0]   = s_tvalid;
    assign s_tready = r_w[0];
    assign idx_w[0] = s_tdata[IDX_W-1:0];
    assign rem_w[0] = s_tdata[IDX_W-1:0];
    assign x_w[0]   = '0;
    assign y_w[0]   = '0;

    generate
        for (genvar k = 0; k < NC; k++) begin : g_cell
            hpim_digit_cell #(
                .K       (k),
                .X_W     (X_W),
                .Y_W     (Y_W),
                .BIN_EN  (k < MAX_BASE2_DIGITS),
                .TERN_EN (k < MAX_BASE3_DIGITS)
            ) u_cell (
                .aclk      (aclk),
                .aresetn   (aresetn),
                .cfg       (cfg),
                .in_valid  (v_w[k]),
                .in_ready  (r_w[k]),
                .in_idx    (idx_w[k]),
                .in_rem    (rem_w[k]),
                .in_x      (x_w[k]),
                .in_y      (y_w[k]),
                .out_valid (v_w[k+1]),
                .out_ready (r_w[k+1]),
                .out_idx   (idx_w[k+1]),
                .out_rem   (rem_w[k+1]),
                .out_x     (x_w[k+1]),
                .out_y     (y_w[k+1])
            );
        end
    endgenerate

    hpim_addr_stage #(
        .X_W (X_W),
        .Y_W (Y_W)
    ) u_addr (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg           (cfg),
        .in_valid      (v_w[NC]),
        .in_ready      (r_w[NC]),
        .in_idx        (idx_w[NC]),
        .in_x          (x_w[NC]),
        .in_y          (y_w[NC]),
        .out_valid     (m_tvalid),
        .out_ready     (m_tready),
        .pixel_x       (pixel_x),
        .pixel_y       (pixel_y),
        .table_address (table_address),
        .write_enable  (write_enable),
        .index_out     (index_out)
    );

    assign m_tdata = {6'd0, index_out, table_address, pixel_y, pixel_x};
    assign m_tuser = write_enable;

    `ASSERT_SYNC(a_empty_out_takes_input, aclk, aresetn, !m_tvalid |-> s_tready)
    `ASSERT_SYNC(a_outside_zero_addr, aclk, aresetn,
        (m_tvalid && !write_enable) |-> (table_address == '0))
    `ASSERT_SYNC(a_inside_x, aclk, aresetn,
        (m_tvalid && write_enable) |-> ({1'b0, pixel_x} < width_reg))
    `ASSERT_SYNC(a_inside_y, aclk, aresetn,
        (m_tvalid && write_enable) |-> (pixel_y < height_reg))

endmodule
